>>> hdl/bpdm_pkg.sv
// Constants, widths and the log2 fraction table for the block power meter.
package bpdm_pkg;

   localparam int SAMPLE_BITS       = 16;
   localparam int LOG_FRACTION_BITS = 6;

   localparam int LEN_BITS       = 13;
   localparam int OUT_BITS       = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   // One squared component reaches 2^(2*SAMPLE_BITS-2); two of them summed over up to
   // 2^LEN_BITS samples need this many bits.
   localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;
   localparam int ENERGY_BITS = 2 * SAMPLE_BITS + LEN_BITS;
   localparam int P_BITS      = $clog2(ENERGY_BITS);

   localparam int TAB_SIZE   = 1 << LOG_FRACTION_BITS;
   localparam int LOG_Q_BITS = 16;
   localparam int T_BITS     = P_BITS + LOG_Q_BITS + 1;

   // 10*log10(2) in Q16.
   localparam int KDB_BITS = 19;
   localparam logic signed [KDB_BITS-1:0] KDB = KDB_BITS'(197283);

   localparam int PROD_BITS   = T_BITS + KDB_BITS;
   localparam int ROUND_SHIFT = 24;
   localparam int Q_BITS      = PROD_BITS - ROUND_SHIFT;
   localparam int LEVEL_BITS  = Q_BITS + 1;

   // Full scale of one squared component is 2^(2*(SAMPLE_BITS-1)), the 0 dB point.
   localparam logic signed [T_BITS-1:0] T_OFFSET =
      T_BITS'((2 * (SAMPLE_BITS - 1)) * (1 << LOG_Q_BITS));
   localparam logic signed [PROD_BITS-1:0] ROUND_BIAS = PROD_BITS'(1 << (ROUND_SHIFT - 1));

   localparam logic [CSR_INDEX_BITS-1:0] REG_BLOCK_LENGTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CORRECTION_DB = 1'b1;

   localparam logic [LEN_BITS-1:0]        BLOCK_LENGTH_RESET  = LEN_BITS'(1024);
   localparam logic signed [OUT_BITS-1:0] CORRECTION_DB_RESET = -OUT_BITS'(2048);

   typedef logic [TAB_SIZE-1:0][LOG_Q_BITS-1:0] log_tab_type;

   // log2 of a Q1.30 mantissa in [1,2), sixteen fraction bits by repeated squaring.
   function automatic logic [LOG_Q_BITS-1:0] log2_frac(input logic [63:0] mant);
      logic [63:0]            x;
      logic [LOG_Q_BITS-1:0] r;
      x = mant;
      r = '0;
      for (int k = 0; k < LOG_Q_BITS; k++) begin
         x = (x * x) >> 30;
         r = r << 1;
         if (x >= (64'd2 << 30)) begin
            r[0] = 1'b1;
            x    = x >> 1;
         end
      end
      return r;
   endfunction

   function automatic log_tab_type build_log_tab();
      log_tab_type tab;
      for (int i = 0; i < TAB_SIZE; i++) begin
         tab[i] = log2_frac(64'(TAB_SIZE + i) << (30 - LOG_FRACTION_BITS));
      end
      return tab;
   endfunction

   localparam log_tab_type LOG_TAB = build_log_tab();

endpackage

>>> hdl/block_power_db_meter.sv
// Block power meter: I/Q energy accumulation and conversion to a level in 1/256 dB.
// A result is registered through stages 0 to 6 after the last sample of its block and is
// valid on rsp from the output register. Throughput: one sample per cycle while req_stall is low.
// A waiting result does not block the input; samples keep flowing while rsp is stalled
// until the pipeline behind the output register is full.
// Reset is synchronous: it empties the pipeline, clears the energy sum and sample count,
// and loads block_length with 1024 and correction_db with -2048 (-8 dB).
module block_power_db_meter (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [bpdm_pkg::SAMPLE_BITS-1:0]    req_sample_re,
   input  logic signed [bpdm_pkg::SAMPLE_BITS-1:0]    req_sample_im,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [bpdm_pkg::OUT_BITS-1:0]       rsp_level_db,
   output logic                                       rsp_energy_zero,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [bpdm_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [bpdm_pkg::CSR_DATA_BITS-1:0]         csr_data
);
   import bpdm_pkg::*;

   localparam logic signed [LEVEL_BITS-1:0] LEVEL_MAX = LEVEL_BITS'((1 << (OUT_BITS - 1)) - 1);
   localparam logic signed [LEVEL_BITS-1:0] LEVEL_MIN = -LEVEL_BITS'(1 << (OUT_BITS - 1));
   localparam logic [LEN_BITS:0]            LEN_WRAP  = (LEN_BITS + 1)'(1 << LEN_BITS);

   // Configuration registers. Writes must arrive only while the meter is idle; the block does not enforce this.
   logic [LEN_BITS-1:0]        block_length_ff;
   logic signed [OUT_BITS-1:0] correction_db_ff;

   // Pipeline stage enables: a stage loads when it is empty or its successor moves on.
   logic en0, en1, en2, en3, en4, en5, en6;

   // Stage 0: captured sample.
   logic                          v0_ff, v0_in;
   logic signed [SAMPLE_BITS-1:0] re0_ff, im0_ff;

   // Stage 1: the two squared components.
   logic                            v1_ff, v1_in;
   logic [SQ_BITS-1:0]              sq_re1_ff, sq_im1_ff, sq_re_in, sq_im_in;
   logic signed [2*SAMPLE_BITS-1:0] re_sq_full, im_sq_full;

   // Stage 2: accumulator, sample counter and the finished block energy.
   logic [ENERGY_BITS-1:0] energy_sum_ff, energy_sum_in, sum_total;
   logic [LEN_BITS-1:0]    sample_count_ff, sample_count_in;
   logic [LEN_BITS:0]      count_inc, block_len;
   logic                   block_end;
   logic                   v2_ff, v2_in;
   logic [ENERGY_BITS-1:0] blk_energy2_ff;

   // Stage 3: leading-one position and zero flag.
   logic                   v3_ff;
   logic [P_BITS-1:0]      p3_ff, p_in;
   logic [ENERGY_BITS-1:0] e3_ff;
   logic                   zero3_ff, zero_in;

   // Stage 4: log2 of the energy relative to full scale, in Q.16.
   logic                         v4_ff;
   logic signed [T_BITS-1:0]     t4_ff, t_in;
   logic                         zero4_ff;
   logic [P_BITS-1:0]            shamt;
   logic [ENERGY_BITS-1:0]       e_aligned;
   logic [LOG_FRACTION_BITS-1:0] frac;

   // Stage 5: scaled to dB.
   logic                        v5_ff;
   logic signed [PROD_BITS-1:0] prod5_ff, prod_in;
   logic                        zero5_ff;

   // Stage 6: output register.
   logic                         v6_ff;
   logic signed [OUT_BITS-1:0]   level6_ff, level_in;
   logic                         zero6_ff;
   logic signed [PROD_BITS-1:0]  rounded;
   logic signed [Q_BITS-1:0]     q_level;
   logic signed [LEVEL_BITS-1:0] level_sum;

   // The result register drains whenever the consumer does not stall, and every earlier
   // stage moves when the one after it has room. Only block ends leave stage 2, so
   // samples in the middle of a block keep being accepted while a result waits.
   always_comb begin
      en6 = !v6_ff || !rsp_stall;
      en5 = !v5_ff || en6;
      en4 = !v4_ff || en5;
      en3 = !v3_ff || en4;
      en2 = !v2_ff || en3;
      en1 = !v1_ff || en2;
      en0 = !v0_ff || en1;
   end

   assign req_stall = !en0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff  <= BLOCK_LENGTH_RESET;
         correction_db_ff <= CORRECTION_DB_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_BLOCK_LENGTH:  block_length_ff  <= csr_data[LEN_BITS-1:0];
            REG_CORRECTION_DB: correction_db_ff <= $signed(csr_data[OUT_BITS-1:0]);
            default:           ;
         endcase
      end
   end

   // Stage 0 takes a transaction straight from the port.
   assign v0_in = req_valid;

   always_ff @(posedge clock) begin
      if (en0) begin
         re0_ff <= req_sample_re;
         im0_ff <= req_sample_im;
      end
   end

   // Stage 1: squaring. A square is never negative and fits one bit less than the product.
   always_comb begin
      re_sq_full = re0_ff * re0_ff;
      im_sq_full = im0_ff * im0_ff;
      sq_re_in   = re_sq_full[SQ_BITS-1:0];
      sq_im_in   = im_sq_full[SQ_BITS-1:0];
      v1_in      = v0_ff;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         sq_re1_ff <= sq_re_in;
         sq_im1_ff <= sq_im_in;
      end
   end

   // Stage 2: accumulate. A block length of zero counts as the full counter range, and a
   // length lowered in mid-block ends the block at the next sample.
   always_comb begin
      sum_total = energy_sum_ff + ENERGY_BITS'(sq_re1_ff) + ENERGY_BITS'(sq_im1_ff);
      count_inc = {1'b0, sample_count_ff} + (LEN_BITS + 1)'(1);
      block_len = (block_length_ff == '0) ? LEN_WRAP : {1'b0, block_length_ff};
      block_end = (count_inc >= block_len);

      energy_sum_in   = energy_sum_ff;
      sample_count_in = sample_count_ff;
      if (v1_ff && en2) begin
         if (block_end) begin
            energy_sum_in   = '0;
            sample_count_in = '0;
         end else begin
            energy_sum_in   = sum_total;
            sample_count_in = count_inc[LEN_BITS-1:0];
         end
      end
      v2_in = v1_ff && block_end;
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         blk_energy2_ff <= sum_total;
      end
   end

   // Stage 3: position of the leading one of the block energy.
   always_comb begin
      p_in = '0;
      for (int i = 0; i < ENERGY_BITS; i++) begin
         if (blk_energy2_ff[i]) begin
            p_in = P_BITS'(i);
         end
      end
      zero_in = (blk_energy2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         p3_ff    <= p_in;
         e3_ff    <= blk_energy2_ff;
         zero3_ff <= zero_in;
      end
   end

   // Stage 4: left-align the energy, take the bits under the leading one as the table
   // index and add the table fraction to the integer part of the logarithm, less the full-scale offset.
   always_comb begin
      shamt     = P_BITS'(ENERGY_BITS - 1) - p3_ff;
      e_aligned = e3_ff << shamt;
      frac      = e_aligned[ENERGY_BITS-2 -: LOG_FRACTION_BITS];
      t_in      = $signed({1'b0, p3_ff, LOG_TAB[frac]}) - T_OFFSET;
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         t4_ff    <= t_in;
         zero4_ff <= zero3_ff;
      end
   end

   // Stage 5: scale log2 to decibels.
   assign prod_in = t4_ff * KDB;

   always_ff @(posedge clock) begin
      if (en5) begin
         prod5_ff <= prod_in;
         zero5_ff <= zero4_ff;
      end
   end

   // Stage 6: round half up to 1/256 dB, add the calibration offset and saturate.
   // Zero energy reports the floor of the output range.
   always_comb begin
      rounded   = prod5_ff + ROUND_BIAS;
      q_level   = $signed(rounded[PROD_BITS-1:ROUND_SHIFT]);
      level_sum = LEVEL_BITS'(q_level) + LEVEL_BITS'(correction_db_ff);
      priority if (zero5_ff) begin
         level_in = LEVEL_MIN[OUT_BITS-1:0];
      end else if (level_sum > LEVEL_MAX) begin
         level_in = LEVEL_MAX[OUT_BITS-1:0];
      end else if (level_sum < LEVEL_MIN) begin
         level_in = LEVEL_MIN[OUT_BITS-1:0];
      end else begin
         level_in = level_sum[OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         level6_ff <= level_in;
         zero6_ff  <= zero5_ff;
      end
   end

   // Control state: valid bits, accumulator and counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff           <= 1'b0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         v3_ff           <= 1'b0;
         v4_ff           <= 1'b0;
         v5_ff           <= 1'b0;
         v6_ff           <= 1'b0;
         energy_sum_ff   <= '0;
         sample_count_ff <= '0;
      end else begin
         energy_sum_ff   <= energy_sum_in;
         sample_count_ff <= sample_count_in;
         if (en0) v0_ff <= v0_in;
         if (en1) v1_ff <= v1_in;
         if (en2) v2_ff <= v2_in;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   assign rsp_valid       = v6_ff;
   assign rsp_level_db    = level6_ff;
   assign rsp_energy_zero = zero6_ff;

endmodule
